>>> rtl/bmm_pkg.sv
`default_nettype none
package bmm_pkg;

  // Field widths fixed by the item formats
  localparam int COORD_BITS   = 24;
  localparam int NORM_BITS    = 17;
  localparam int FLIP_BITS    = 3;
  localparam int MIN_EXT_BITS = 24;
  localparam int NUM_AXES     = 3;

  // Configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FLIP_MASK  = 1'b0,
    CFG_MIN_EXTENT = 1'b1
  } cfg_idx_t;

  localparam logic [FLIP_BITS-1:0]    FLIP_MASK_RST  = 3'd6;
  localparam logic [MIN_EXT_BITS-1:0] MIN_EXTENT_RST = '0;

  // Mode codes
  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_NORM  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Extremes of a coordinate
  localparam coord_t COORD_MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic   mode;
    logic   first_vertex;
    coord_t x_coord;
    coord_t y_coord;
    coord_t z_coord;
  } in_item_t;

  typedef struct packed {
    logic [NORM_BITS-1:0] norm_x;
    logic [NORM_BITS-1:0] norm_y;
    logic [NORM_BITS-1:0] norm_z;
    logic [NUM_AXES-1:0]  flat_axes;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/bmm_div.sv
`default_nettype none
// Radix-2 restoring divider for a proper fraction: quotient = (dividend << FRAC_BITS) / divisor,
// with dividend < divisor. One quotient bit per cycle.
module bmm_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [bmm_pkg::COORD_BITS-1:0] dividend,
  input  wire logic [bmm_pkg::COORD_BITS-1:0] divisor,
  output logic                                done,
  output logic [FRAC_BITS-1:0]                quotient
);
  import bmm_pkg::*;

  localparam int CNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [COORD_BITS-1:0] dvs_r, dvs_nxt;
  logic [FRAC_BITS-1:0]  quo_r, quo_nxt;

  logic [COORD_BITS:0]   rem2;
  logic [COORD_BITS:0]   diff;

  // Shift-subtract step
  always_comb begin
    rem2     = {rem_r, 1'b0};
    diff     = rem2 - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(FRAC_BITS - 1);
      rem_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[COORD_BITS]) begin
        rem_nxt = diff[COORD_BITS-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem2[COORD_BITS-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/bbox_minmax_normalizer.sv
`default_nettype none
// Accumulate vertex: accepted in idle; bounds update on the transfer edge.
// Normalize vertex: per axis a setup state, then the shared divider (setup only for flat or
// clamped axes), axes one after another through the single divider, then the result moves
// to the output register once that register is free.
// Synchronous active-low reset: flip_mask=6, min_extent=0, bounds to empty, no result pending.
module bbox_minmax_normalizer #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bmm_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bmm_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [bmm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [bmm_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import bmm_pkg::*;

  localparam int QW  = FRAC_BITS + 1;
  localparam int EW  = COORD_BITS + 1;
  localparam int CMW = (COORD_BITS > MIN_EXT_BITS) ? COORD_BITS : MIN_EXT_BITS;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_DIV   = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [1:0]              k_r, k_nxt;
  logic [FLIP_BITS-1:0]    flip_r;
  logic [MIN_EXT_BITS-1:0] min_ext_r;
  coord_t                  min_r [NUM_AXES];
  coord_t                  max_r [NUM_AXES];
  coord_t                  p_r   [NUM_AXES];
  logic [QW-1:0]           res_r [NUM_AXES];
  logic [NUM_AXES-1:0]     flat_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  coord_t                  pin [NUM_AXES];
  logic                    in_xfer;
  logic                    norm_xfer;
  logic                    accum_xfer;

  logic signed [EW-1:0]    ext_s;
  logic signed [EW-1:0]    off_s;
  logic                    ax_flat;
  logic                    ax_low;
  logic                    ax_high;
  logic                    axis_done;
  logic [QW-1:0]           ax_res;
  logic                    div_start;
  logic                    div_done;
  logic [FRAC_BITS-1:0]    div_q;
  logic                    out_load;
  logic [QW+NORM_BITS-1:0] wide [NUM_AXES];

  // Saturating negate
  function automatic coord_t sat_neg(input coord_t v);
    coord_t r;
    if (v == COORD_MINV) r = COORD_MAXV;
    else                 r = -v;
    return r;
  endfunction

  // Input coordinates after the flip mask
  always_comb begin
    pin[0] = flip_r[0] ? sat_neg(in_data.x_coord) : in_data.x_coord;
    pin[1] = flip_r[1] ? sat_neg(in_data.y_coord) : in_data.y_coord;
    pin[2] = flip_r[2] ? sat_neg(in_data.z_coord) : in_data.z_coord;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign norm_xfer  = in_xfer && (in_data.mode == MODE_NORM);
  assign accum_xfer = in_xfer && (in_data.mode == MODE_ACCUM);

  // Per-axis setup: extent, offset and the special cases
  always_comb begin
    ext_s   = {max_r[k_r][COORD_BITS-1], max_r[k_r]} - {min_r[k_r][COORD_BITS-1], min_r[k_r]};
    off_s   = {p_r[k_r][COORD_BITS-1], p_r[k_r]} - {min_r[k_r][COORD_BITS-1], min_r[k_r]};
    ax_flat = ext_s[EW-1] ||
              (CMW'(ext_s[COORD_BITS-1:0]) <= CMW'(min_ext_r));
    ax_low  = off_s[EW-1] || (off_s == '0);
    ax_high = (off_s >= ext_s);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    div_start = 1'b0;
    axis_done = 1'b0;
    ax_res    = '0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (norm_xfer) begin
          state_nxt = S_SETUP;
          k_nxt     = '0;
        end
      end
      S_SETUP: begin
        if (ax_flat || ax_low) begin
          axis_done = 1'b1;
          ax_res    = '0;
        end else if (ax_high) begin
          axis_done = 1'b1;
          ax_res    = ONE_Q;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          axis_done = 1'b1;
          ax_res    = {1'b0, div_q};
          state_nxt = S_SETUP;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (axis_done) begin
      if (k_r == 2'(NUM_AXES - 1)) begin
        state_nxt = S_FIN;
      end else begin
        k_nxt = k_r + 2'd1;
        if (state_r == S_DIV) state_nxt = S_SETUP;
      end
    end
  end

  bmm_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (off_s[COORD_BITS-1:0]),
    .divisor  (ext_s[COORD_BITS-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Control, configuration and bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      flip_r      <= FLIP_MASK_RST;
      min_ext_r   <= MIN_EXTENT_RST;
      for (int i = 0; i < NUM_AXES; i++) begin
        min_r[i] <= COORD_MAXV;
        max_r[i] <= COORD_MINV;
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (out_load)                  out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FLIP_MASK:  flip_r    <= cfg_wdata[FLIP_BITS-1:0];
          CFG_MIN_EXTENT: min_ext_r <= cfg_wdata[MIN_EXT_BITS-1:0];
          default: ;
        endcase
      end
      if (accum_xfer) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (in_data.first_vertex) begin
            min_r[i] <= pin[i];
            max_r[i] <= pin[i];
          end else begin
            if (pin[i] < min_r[i]) min_r[i] <= pin[i];
            if (pin[i] > max_r[i]) max_r[i] <= pin[i];
          end
        end
      end
    end
  end

  // Result packing, masked to the field width
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      wide[i] = {{NORM_BITS{1'b0}}, res_r[i]};
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    if (norm_xfer) begin
      for (int i = 0; i < NUM_AXES; i++) p_r[i] <= pin[i];
    end
    if (axis_done) begin
      res_r[k_r]  <= ax_res;
      flat_r[k_r] <= (state_r == S_SETUP) && ax_flat;
    end
    if (out_load) begin
      out_r.norm_x    <= wide[0][NORM_BITS-1:0];
      out_r.norm_y    <= wide[1][NORM_BITS-1:0];
      out_r.norm_z    <= wide[2][NORM_BITS-1:0];
      out_r.flat_axes <= flat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
